/* rtl/cmrs_pkg.sv */
// Package for the complex multiplier with symmetric rounding and saturation.
// Holds the default data width, the shift register width, the shift limit and the stage count.
// No dependencies; every rtl file of this block imports it.
`timescale 1ns / 1ps

package cmrs_pkg;

  // Default width of every operand and result part.
  parameter int unsigned DataWidthDef = 32;

  // Width of the output shift register.
  parameter int unsigned ShiftW = 6;

  // A shift at or above this value only keeps the sign of the part.
  parameter logic [ShiftW-1:0] ShiftLimit = 6'd63;

  // Number of register stages from input beat to result beat.
  parameter int unsigned NumStages = 5;

endpackage

/* rtl/complex_mul_round_saturate.sv */
// An accepted input beat passes through every stage below to its result beat.
// Throughput: one complex product per cycle while the output is not stalled; a stage
// takes a new beat when empty or when its content moves on; bubbles collapse on stall.
// Stages: multiply, add, magnitude, round and shift, saturate into output register.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears shift_q to 0.
// Depends on cmrs_pkg.
`timescale 1ns / 1ps

module complex_mul_round_saturate import cmrs_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [ShiftW-1:0]            cfg_data_i,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] a_real_i,
  input  logic signed [DATA_WIDTH-1:0] a_imag_i,
  input  logic signed [DATA_WIDTH-1:0] b_real_i,
  input  logic signed [DATA_WIDTH-1:0] b_imag_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] prod_real_o,
  output logic signed [DATA_WIDTH-1:0] prod_imag_o
);

  localparam int unsigned ProdW = 2 * DATA_WIDTH;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned MagW  = ProdW;
  localparam int unsigned RndW  = ProdW + 1;

  // Saturation bounds on the shifted magnitude.
  localparam logic [RndW-1:0] SatPos = {{(RndW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [RndW-1:0] SatNeg = SatPos + RndW'(1);

  // Output shift register.
  logic [ShiftW-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (cfg_we_i) begin
      shift_q <= cfg_data_i;
    end
  end

  // Stage valid bits and per-stage load enables; a stage loads when it is
  // empty or when its beat moves on to the next stage.
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] load;

  always_comb begin
    load[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  assign in_stall_o  = !load[0];
  assign out_valid_o = valid_q[NumStages-1];

  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage 1: the four partial products.
  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [ProdW-1:0] p_rr_d, p_ii_d, p_ri_d, p_ir_d;

  assign p_rr_d = a_real_i * b_real_i;
  assign p_ii_d = a_imag_i * b_imag_i;
  assign p_ri_d = a_real_i * b_imag_i;
  assign p_ir_d = a_imag_i * b_real_i;

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      p_rr_q <= p_rr_d;
      p_ii_q <= p_ii_d;
      p_ri_q <= p_ri_d;
      p_ir_q <= p_ir_d;
    end
  end

  // Stage 2: exact real and imaginary sums, one bit wider than a product.
  logic signed [SumW-1:0] sum_re_q, sum_im_q;
  logic signed [SumW-1:0] sum_re_d, sum_im_d;

  assign sum_re_d = {p_rr_q[ProdW-1], p_rr_q} - {p_ii_q[ProdW-1], p_ii_q};
  assign sum_im_d = {p_ri_q[ProdW-1], p_ri_q} + {p_ir_q[ProdW-1], p_ir_q};

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
    end
  end

  // Stage 3: split each sum into sign and magnitude.
  logic            neg_re_q, neg_im_q;
  logic [MagW-1:0] mag_re_q, mag_im_q;
  logic [MagW-1:0] mag_re_d, mag_im_d;

  assign mag_re_d = sum_re_q[SumW-1] ? MagW'(-sum_re_q) : MagW'(sum_re_q);
  assign mag_im_d = sum_im_q[SumW-1] ? MagW'(-sum_im_q) : MagW'(sum_im_q);

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      neg_re_q <= sum_re_q[SumW-1];
      neg_im_q <= sum_im_q[SumW-1];
      mag_re_q <= mag_re_d;
      mag_im_q <= mag_im_d;
    end
  end

  // Stage 4: add half an LSB to the magnitude, then shift right.
  logic [RndW-1:0] half;
  logic [RndW-1:0] shr_re_d, shr_im_d;
  logic [RndW-1:0] shr_re_q, shr_im_q;
  logic            neg4_re_q, neg4_im_q;

  always_comb begin
    if (shift_q == '0) begin
      half = '0;
    end else begin
      half = RndW'(1) << (shift_q - ShiftW'(1));
    end
    shr_re_d = ({1'b0, mag_re_q} + half) >> shift_q;
    shr_im_d = ({1'b0, mag_im_q} + half) >> shift_q;
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      neg4_re_q <= neg_re_q;
      neg4_im_q <= neg_im_q;
      shr_re_q  <= shr_re_d;
      shr_im_q  <= shr_im_d;
    end
  end

  // Stage 5: put the sign back and saturate into the output register.
  function automatic logic [DATA_WIDTH-1:0] sat_part(input logic            neg,
                                                     input logic [RndW-1:0] mag,
                                                     input logic            big_shift);
    logic [RndW-1:0] lim_mag;
    lim_mag = '0;
    if (big_shift) begin
      sat_part = neg ? '1 : '0;
    end else if (neg) begin
      lim_mag  = (mag > SatNeg) ? SatNeg : mag;
      sat_part = DATA_WIDTH'(-lim_mag);
    end else begin
      lim_mag  = (mag > SatPos) ? SatPos : mag;
      sat_part = DATA_WIDTH'(lim_mag);
    end
  endfunction

  logic                  big_shift;
  logic [DATA_WIDTH-1:0] prod_real_d, prod_imag_d;
  logic [DATA_WIDTH-1:0] prod_real_q, prod_imag_q;

  assign big_shift   = (shift_q >= ShiftLimit);
  assign prod_real_d = sat_part(neg4_re_q, shr_re_q, big_shift);
  assign prod_imag_d = sat_part(neg4_im_q, shr_im_q, big_shift);

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      prod_real_q <= prod_real_d;
      prod_imag_q <= prod_imag_d;
    end
  end

  assign prod_real_o = prod_real_q;
  assign prod_imag_o = prod_imag_q;

  // Checks on the pipeline control.
  logic beat_in, beat_out;

  assign beat_in  = in_valid_i && !in_stall_o;
  assign beat_out = out_valid_o && !out_stall_i;

  // A beat taken with none leaving raises the occupancy by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_in && !beat_out) |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("pipeline occupancy did not grow on an input beat");

  // An empty first stage never pushes back on the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0] |-> !in_stall_o)
    else $error("input stalled while the first stage is empty");

  // With a shift at the limit only zero or minus one can come out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (shift_q >= ShiftLimit)) |->
      ((prod_real_o == '0 || prod_real_o == '1) && (prod_imag_o == '0 || prod_imag_o == '1)))
    else $error("large shift gave a value other than zero or minus one");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for complex_mul_round_saturate.
// Predicts each rounded, saturated complex product and checks the output beats.
// Depends on cmrs_pkg and the complex_mul_round_saturate RTL.
`timescale 1ns / 1ps

module tb_top;
  import cmrs_pkg::*;

  localparam int DW = DataWidthDef;
  localparam int WIDE = 2 * DW + 2;
  localparam logic signed [DW-1:0] MinVal = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MaxVal = {1'b0, {(DW-1){1'b1}}};

  typedef logic signed [DW-1:0] part_t;
  typedef struct packed {
    part_t re;
    part_t im;
  } product_t;

  // Holds the expected products in order and checks each output beat against them.
  class product_scoreboard;
    product_t expected_products[$];
    logic [ShiftW-1:0] shift_amt = '0;
    int error_count = 0;

    task report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
    endtask

    // Symmetric rounding of one exact part, then saturation to the part width.
    function part_t round_part(input logic signed [WIDE-1:0] exact);
      logic neg;
      logic [WIDE-1:0] mag;
      logic [WIDE-1:0] m;
      logic [WIDE-1:0] lim;
      neg = exact < 0;
      mag = neg ? $unsigned(-exact) : $unsigned(exact);
      lim = {{(WIDE-1){1'b0}}, 1'b1} << (DW - 1);
      if (shift_amt >= ShiftLimit) begin
        return neg ? '1 : '0;
      end
      if (shift_amt == 0) begin
        m = mag;
      end else begin
        m = (mag + ({{(WIDE-1){1'b0}}, 1'b1} << (shift_amt - 1))) >> shift_amt;
      end
      if (neg) begin
        if (m > lim) begin
          m = lim;
        end
        m = -m;
        return m[DW-1:0];
      end
      if (m > lim - 1) begin
        m = lim - 1;
      end
      return m[DW-1:0];
    endfunction

    // Called for every accepted input beat.
    function void note_operands(input part_t ar, input part_t ai, input part_t br,
                                input part_t bi);
      logic signed [WIDE-1:0] xr, xi, yr, yi;
      product_t p;
      xr = ar;
      xi = ai;
      yr = br;
      yi = bi;
      p.re = round_part(xr * yr - xi * yi);
      p.im = round_part(xr * yi + xi * yr);
      expected_products.push_back(p);
    endfunction

    // Called for every accepted output beat.
    task check_product(input part_t got_re, input part_t got_im);
      product_t p;
      if (expected_products.size() == 0) begin
        report_mismatch($sformatf("unexpected product re=%0d im=%0d", got_re, got_im));
        return;
      end
      p = expected_products.pop_front();
      if (got_re !== p.re) begin
        report_mismatch($sformatf("prod_real got %0d want %0d", got_re, p.re));
      end
      if (got_im !== p.im) begin
        report_mismatch($sformatf("prod_imag got %0d want %0d", got_im, p.im));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [ShiftW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  part_t a_real_i, a_imag_i, b_real_i, b_imag_i;
  logic out_valid_o;
  logic out_stall_i;
  part_t prod_real_o, prod_imag_o;

  int send_idle_pct = 37;
  int stall_pct = 81;
  product_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  complex_mul_round_saturate #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .a_real_i   (a_real_i),
    .a_imag_i   (a_imag_i),
    .b_real_i   (b_real_i),
    .b_imag_i   (b_imag_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .prod_real_o(prod_real_o),
    .prod_imag_o(prod_imag_o)
  );

  // Offers one operand beat after a random gap and waits until it is taken.
  task automatic send_operands(input part_t ar, input part_t ai, input part_t br,
                               input part_t bi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_real_i <= ar;
    a_imag_i <= ai;
    b_real_i <= br;
    b_imag_i <= bi;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    sb.note_operands(ar, ai, br, bi);
  endtask

  // Waits until every expected product has come out.
  task automatic wait_drained();
    while (sb.expected_products.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Writes the shift register once the pipeline is empty.
  task automatic write_shift(input logic [ShiftW-1:0] value);
    in_valid_i <= 1'b0;
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.shift_amt = value;
  endtask

  // Random operand: mostly values of a random bit length, sometimes an extreme.
  function automatic part_t rand_operand();
    int w;
    part_t v;
    case ($urandom_range(0, 9))
      0: return MinVal;
      1: return MaxVal;
      2: return '0;
      3: return '1;
      default: begin
        w = $urandom_range(1, DW);
        v = $urandom;
        v = (v << (DW - w)) >>> (DW - w);
        return v;
      end
    endcase
  endfunction

  // Output side: checks accepted beats and stalls at random.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_product(prod_real_o, prod_imag_o);
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Main stimulus.
  initial begin
    int shift_plan[9];
    int phase;
    int n;
    shift_plan = '{0, 63, 16, 1, 62, 31, 32, -1, -1};
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    a_real_i <= '0;
    a_imag_i <= '0;
    b_real_i <= '0;
    b_imag_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset shift of zero: saturation only.
    send_operands('0, '0, '0, '0);
    send_operands(MinVal, MinVal, MinVal, MinVal);
    send_operands(MaxVal, MaxVal, MaxVal, MaxVal);
    send_operands(MaxVal, MinVal, MinVal, MaxVal);
    send_operands(1, 0, 1, 0);
    send_operands(-1, 0, 1, 0);
    send_operands(MaxVal, 0, MaxVal, 0);
    send_operands(MinVal, 0, MaxVal, 0);
    send_operands(0, MinVal, 0, MinVal);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC);
    send_operands(-1, -1, -1, -1);

    // Rounding ties go away from zero; small negative values round to zero.
    write_shift(ShiftW'(2));
    send_operands(1, 0, 1, 0);
    send_operands(2, 0, 1, 0);
    send_operands(-2, 0, 1, 0);
    send_operands(-1, 0, 1, 0);
    send_operands(6, 0, 1, 0);
    send_operands(-6, 0, 1, 0);
    send_operands(MinVal, MinVal, MinVal, MinVal);

    // Largest shift keeps only the sign.
    write_shift(ShiftLimit);
    send_operands(5, 0, 1, 0);
    send_operands(-5, 0, 1, 0);
    send_operands(MinVal, MinVal, MinVal, MinVal);
    send_operands(MinVal, 0, MaxVal, 0);

    // Random phases, each with its own shift; the idling pattern changes at phases 3 and 6.
    for (phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 81;
        stall_pct = 37;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      write_shift(ShiftW'(shift_plan[phase] < 0 ? $urandom_range(0, 63)
                                                 : shift_plan[phase]));
      for (n = 0; n < 100; n++) begin
        send_operands(rand_operand(), rand_operand(), rand_operand(), rand_operand());
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (NumStages * 4) @(posedge clk_i);
    if (sb.expected_products.size() != 0) begin
      sb.report_mismatch($sformatf("%0d products never came out",
                                   sb.expected_products.size()));
    end
    if (sb.error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
